FILE: hdl/bbr_pkg.sv
// ----------------------------------------------------------------------------
// bbr_pkg
// Shared types and constants for the bit block regrouper.
// ----------------------------------------------------------------------------
package bbr_pkg;

  localparam int unsigned DATA_W        = 64;
  localparam int unsigned MAX_WIDTH_DEF = 64;
  localparam int unsigned CFG_W         = 7;
  localparam int unsigned CFG_IDX_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_BITS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_BITS = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] CFG_RESET_WIDTH = CFG_W'(8);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  // result of one merge step
  typedef struct packed {
    logic emit;
    logic last;
    logic fin;
    logic done;
  } step_t;

  // sequencer controls to the datapath registers
  typedef struct packed {
    logic load;
    logic advance;
    logic out_load;
  } ctrl_t;

endpackage

FILE: hdl/bbr_merge_unit.sv
// ----------------------------------------------------------------------------
// bbr_merge_unit
// Shared shift/merge unit: moves one chunk of source bits into the pending
// target word per step.
// ----------------------------------------------------------------------------
module bbr_merge_unit #(
  parameter int unsigned MAX_WIDTH = bbr_pkg::MAX_WIDTH_DEF,
  parameter int unsigned CW        = $clog2(MAX_WIDTH + 1)
) (
  input  logic [MAX_WIDTH-1:0] src_i,
  input  logic [CW-1:0]        rem_i,
  input  logic [MAX_WIDTH-1:0] pend_i,
  input  logic [CW-1:0]        cnt_i,
  input  logic [CW-1:0]        tgt_i,
  input  logic                 end_i,
  output logic [MAX_WIDTH-1:0] src_o,
  output logic [CW-1:0]        rem_o,
  output logic [MAX_WIDTH-1:0] pend_o,
  output logic [CW-1:0]        cnt_o,
  output logic [MAX_WIDTH-1:0] word_o,
  output bbr_pkg::step_t       step_o
);

  logic [CW-1:0]        space;
  logic [CW-1:0]        chunk;
  logic [MAX_WIDTH-1:0] chunk_mask;
  logic [MAX_WIDTH-1:0] merged;
  logic [CW-1:0]        cnt_sum;
  logic [CW-1:0]        rem_next;
  logic                 full;

  always_comb begin
    space      = tgt_i - cnt_i;
    chunk      = (rem_i < space) ? rem_i : space;
    chunk_mask = ~({MAX_WIDTH{1'b1}} << chunk);
    merged     = pend_i | ((src_i & chunk_mask) << cnt_i);
    cnt_sum    = cnt_i + chunk;
    rem_next   = rem_i - chunk;
    full       = (cnt_sum == tgt_i);

    step_o.done = (rem_next == '0);
    step_o.emit = full || (step_o.done && end_i);
    // last word of the transaction when the leftover bits cannot fill another
    step_o.last = step_o.done || (full && !end_i && (rem_next < tgt_i));
    step_o.fin  = step_o.done && end_i;

    src_o  = src_i >> chunk;
    rem_o  = rem_next;
    word_o = merged;
    pend_o = step_o.emit ? '0 : merged;
    cnt_o  = step_o.emit ? '0 : cnt_sum;
  end

endmodule

FILE: hdl/bbr_seq.sv
// ----------------------------------------------------------------------------
// bbr_seq
// Sequencer: takes one transaction, steps the merge unit until the source
// word is used up, and owns the output valid flag.
// ----------------------------------------------------------------------------
module bbr_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 out_ready_i,
  input  bbr_pkg::step_t       step_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  output bbr_pkg::ctrl_t       ctrl_o
);

  bbr_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      bbr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = bbr_pkg::ST_RUN;
        end
      end
      bbr_pkg::ST_RUN: begin
        if (ctrl_o.advance && step_i.done) begin
          state_d = bbr_pkg::ST_IDLE;
        end
      end
      default: state_d = bbr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_free        = !out_valid_q || out_ready_i;
    in_ready_o      = (state_q == bbr_pkg::ST_IDLE);
    ctrl_o.load     = in_ready_o && in_valid_i;
    ctrl_o.advance  = (state_q == bbr_pkg::ST_RUN) && (!step_i.emit || out_free);
    ctrl_o.out_load = ctrl_o.advance && step_i.emit;
    if (ctrl_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
    out_valid_o = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bbr_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: hdl/bit_block_regrouper.sv
// ----------------------------------------------------------------------------
// bit_block_regrouper
// Bit-width gearbox: repacks source blocks into target blocks, LSB first.
// ----------------------------------------------------------------------------
// Operation: a transaction is taken while idle, then one merge step per cycle
//   unless a step that emits a word waits for the output register to free;
//   a step completes a target word or ends with bits left pending or flushed.
// Throughput: a new source transaction is taken only once the last one is done,
//   set by the single shift/merge unit; s_axis_tready is low while it works.
// Reset: widths return to 8/8, pending bits cleared, no output valid.
// ----------------------------------------------------------------------------
module bit_block_regrouper #(
  parameter int unsigned MAX_WIDTH = bbr_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bbr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bbr_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [bbr_pkg::DATA_W-1:0]    s_axis_tdata,  // source_word
  input  logic                          s_axis_tlast,  // stream_end
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [bbr_pkg::DATA_W-1:0]    m_axis_tdata,  // target_word
  output logic                          m_axis_tlast,  // run_last
  output logic                          m_axis_tuser   // final_block
);

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam logic [bbr_pkg::CFG_W-1:0] MAX_CFG = bbr_pkg::CFG_W'(MAX_WIDTH);

  logic [bbr_pkg::CFG_W-1:0] src_cfg_q;
  logic [bbr_pkg::CFG_W-1:0] tgt_cfg_q;
  logic [CW-1:0]             s_eff;
  logic [CW-1:0]             t_eff;

  logic [MAX_WIDTH-1:0] src_q, src_d, src_step;
  logic [CW-1:0]        rem_q, rem_d, rem_step;
  logic [MAX_WIDTH-1:0] pend_q, pend_d, pend_step;
  logic [CW-1:0]        cnt_q, cnt_d, cnt_step;
  logic                 end_q;
  logic [MAX_WIDTH-1:0] word;
  logic                 cfg_hit;

  logic [bbr_pkg::DATA_W-1:0] out_word_q;
  logic                       out_last_q;
  logic                       out_fin_q;

  bbr_pkg::step_t step;
  bbr_pkg::ctrl_t ctrl;

  always_comb begin
    if (src_cfg_q == '0) begin
      s_eff = CW'(1);
    end else if (src_cfg_q > MAX_CFG) begin
      s_eff = CW'(MAX_WIDTH);
    end else begin
      s_eff = CW'(src_cfg_q);
    end
    if (tgt_cfg_q == '0) begin
      t_eff = s_eff;
    end else if (tgt_cfg_q > MAX_CFG) begin
      t_eff = CW'(MAX_WIDTH);
    end else begin
      t_eff = CW'(tgt_cfg_q);
    end
  end

  bbr_merge_unit #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_merge (
    .src_i  (src_q),
    .rem_i  (rem_q),
    .pend_i (pend_q),
    .cnt_i  (cnt_q),
    .tgt_i  (t_eff),
    .end_i  (end_q),
    .src_o  (src_step),
    .rem_o  (rem_step),
    .pend_o (pend_step),
    .cnt_o  (cnt_step),
    .word_o (word),
    .step_o (step)
  );

  bbr_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .step_i      (step),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .ctrl_o      (ctrl)
  );

  always_comb begin
    cfg_hit = cfg_we_i &&
              ((cfg_idx_i == bbr_pkg::REG_SOURCE_BITS) ||
               (cfg_idx_i == bbr_pkg::REG_TARGET_BITS));
    src_d  = src_q;
    rem_d  = rem_q;
    pend_d = pend_q;
    cnt_d  = cnt_q;
    if (ctrl.load) begin
      src_d = MAX_WIDTH'(s_axis_tdata) & ~({MAX_WIDTH{1'b1}} << s_eff);
      rem_d = s_eff;
    end else if (ctrl.advance) begin
      src_d  = src_step;
      rem_d  = rem_step;
      pend_d = pend_step;
      cnt_d  = cnt_step;
    end
    if (cfg_hit) begin
      pend_d = '0;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_cfg_q <= bbr_pkg::CFG_RESET_WIDTH;
      tgt_cfg_q <= bbr_pkg::CFG_RESET_WIDTH;
      rem_q     <= '0;
      pend_q    <= '0;
      cnt_q     <= '0;
      end_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bbr_pkg::REG_SOURCE_BITS: src_cfg_q <= cfg_wdata_i;
          bbr_pkg::REG_TARGET_BITS: tgt_cfg_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      rem_q  <= rem_d;
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
      if (ctrl.load) begin
        end_q <= s_axis_tlast;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_d;
    if (ctrl.out_load) begin
      out_word_q <= bbr_pkg::DATA_W'(word);
      out_last_q <= step.last;
      out_fin_q  <= step.fin;
    end
  end

  assign m_axis_tdata = out_word_q;
  assign m_axis_tlast = out_last_q;
  assign m_axis_tuser = out_fin_q;

endmodule
